@@ src/blgu_pkg.sv @@
`default_nettype none

package blgu_pkg;

  // Fixed-point formats
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IBITS     = 30;

  // Configuration port
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 31;

  localparam logic [CFG_IW-1:0] CFG_LOSS_MODE      = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_QUANTILE_LEVEL = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HUBER_DELTA    = 2'd2;

  // Loss mode codes
  localparam logic [2:0] MODE_QUAD  = 3'd0;
  localparam logic [2:0] MODE_ABS   = 3'd1;
  localparam logic [2:0] MODE_QUANT = 3'd2;
  localparam logic [2:0] MODE_HUBER = 3'd3;
  localparam logic [2:0] MODE_BINOM = 3'd4;

  // ln2 in Q0.30 and the exponent range limit (63 * ln2)
  localparam logic [29:0] LN2_I   = 30'd744261118;
  localparam logic [45:0] EXP_LIM = 46'd46888450434;

  localparam logic [16:0] Q_ONE    = 17'd65536;
  localparam logic [46:0] LOSS_MAX = '1;

  typedef struct packed {
    logic signed [31:0] true_val;
    logic signed [31:0] pred_val;
    logic [31:0]        obs_weight;
    logic               last_item;
  } blgu_in_t;

  typedef struct packed {
    logic [46:0]        loss_out;
    logic signed [47:0] pseudo_residual;
    logic [46:0]        mean_risk;
    logic               risk_valid;
  } blgu_out_t;

  // floor(2^32 / d) for the small series divisors
  function automatic logic [32:0] recip(input logic [3:0] d);
    logic [32:0] r;
    case (d)
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd13:   r = 33'd330382099;
      default: r = 33'h100000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/blgu_if.sv @@
`default_nettype none

// Observation channel
interface blgu_in_if;
  import blgu_pkg::*;
  logic     valid;
  logic     ready;
  blgu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface blgu_out_if;
  import blgu_pkg::*;
  logic      valid;
  logic      ready;
  blgu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/boosting_loss_gradient_unit.sv @@
// Channel   | Dir | Handshake     | Payload
// item_i    | in  | valid / ready | true_val, pred_val, obs_weight, last_item
// result_o  | out | valid / ready | loss_out, pseudo_residual, mean_risk, risk_valid
// cfg       | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// One observation at a time through a shared multiplier and a radix-2 divider.
// Binomial items use two 31-step divisions, a 6-step ln2 range reduction
// (skipped when exp underflows) and the series loops. A last item adds
// 64 divider steps. rst_ni is asynchronous; the result register lets the
// next item in while a result waits, and a stalled result holds the block
// in its output state.
`default_nettype none

module boosting_loss_gradient_unit #(
  parameter int unsigned MAX_ITEMS = 1048576
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blgu_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [blgu_pkg::CFG_DW-1:0]   cfg_data_i,
  blgu_in_if.sink                       item_i,
  blgu_out_if.source                    result_o
);
  import blgu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_LQ   = 18'h00002,
    S_LQF  = 18'h00004,
    S_EXPC = 18'h00008,
    S_LOGS = 18'h00010,
    S_DIV  = 18'h00020,
    S_TMUL = 18'h00040,
    S_TREC = 18'h00080,
    S_TCOR = 18'h00100,
    S_LSQ  = 18'h00200,
    S_LSQF = 18'h00400,
    S_SIGS = 18'h00800,
    S_BFIN = 18'h01000,
    S_LWLO = 18'h02000,
    S_LWHI = 18'h04000,
    S_LWF  = 18'h08000,
    S_PWF  = 18'h10000,
    S_OUT  = 18'h20000
  } state_e;

  typedef enum logic [1:0] {
    DOP_EXP  = 2'd0,
    DOP_LOG  = 2'd1,
    DOP_SIG  = 2'd2,
    DOP_MEAN = 2'd3
  } div_op_e;

  state_e state_q, state_d;

  // configuration
  logic [2:0]  mode_q;
  logic [16:0] qlvl_q;
  logic [30:0] hdelta_q;

  // accumulators
  logic [63:0]      loss_sum_q;
  logic [CNT_W-1:0] count_q;

  // item registers
  logic [32:0]        a_q;
  logic               rneg_q, rnz_q;
  logic signed [32:0] t_q;
  logic [31:0]        at_q;
  logic               sneg_q, snz_q;
  logic [31:0]        w_q;
  logic               last_q;

  // shared multiplier
  logic [33:0] mul_a;
  logic [32:0] mul_b;
  logic [66:0] prod_q;

  // loss / residual working registers
  logic [47:0] lq_q;
  logic [32:0] mag_q;
  logic        neg_q;
  logic [63:0] acc_q;
  logic [46:0] lw_q;
  logic [47:0] pr_q;

  // series registers
  logic [29:0] f_q;
  logic [5:0]  k_q;
  logic [30:0] term_q, x_q, s2_q, v_q;
  logic [31:0] sum_q;
  logic [3:0]  cnt_q;
  logic        log_ph_q;

  // divider
  logic [63:0] dq_q;
  logic [32:0] rem_q;
  logic [31:0] dv_q;
  logic [6:0]  dcnt_q;
  div_op_e     dop_q;

  // output register
  logic      out_valid_q;
  blgu_out_t out_data_q;
  logic      out_load;

  // ---------------- combinational helpers ----------------
  logic signed [32:0] in_r, in_t;
  logic [32:0]        in_a;
  logic               in_ypos, in_yneg;

  assign in_r    = {item_i.data.true_val[31], item_i.data.true_val}
                 - {item_i.data.pred_val[31], item_i.data.pred_val};
  assign in_a    = in_r[32] ? 33'(-in_r) : 33'(in_r);
  assign in_yneg = item_i.data.true_val[31];
  assign in_ypos = !in_yneg && (item_i.data.true_val != 32'sd0);
  assign in_t    = in_ypos ? -{item_i.data.pred_val[31], item_i.data.pred_val}
                 : (in_yneg ? {item_i.data.pred_val[31], item_i.data.pred_val} : 33'sd0);

  // Huber and quantile terms
  logic        hub_small;
  logic [33:0] hub_span;
  logic [16:0] qlvl_c;
  logic [17:0] qc;
  assign hub_small = a_q < {2'b00, hdelta_q};
  assign hub_span  = {a_q, 1'b0} - {3'b000, hdelta_q};
  assign qlvl_c    = (qlvl_q > Q_ONE) ? Q_ONE : qlvl_q;
  assign qc        = rneg_q ? {Q_ONE - qlvl_c, 1'b0} : {qlvl_c, 1'b0};

  // exp range check
  logic [45:0] u30;
  logic        exp_big;
  assign u30     = {at_q, 14'b0};
  assign exp_big = u30 >= EXP_LIM;

  // series step with reciprocal division by a small constant
  logic [3:0]  dconst;
  logic [30:0] x_new, q0, qcor;
  logic [34:0] qd, rem_c;
  logic [31:0] tay_sum, log_sum;
  logic [30:0] v_new;
  assign dconst  = log_ph_q ? {cnt_q[2:0], 1'b1} : cnt_q;
  assign x_new   = prod_q[60:30];
  assign q0      = prod_q[62:32];
  assign qd      = 35'(q0) * 35'(dconst);
  assign rem_c   = {4'b0000, x_q} - qd;
  assign qcor    = (rem_c >= 35'(dconst)) ? q0 + 31'd1 : q0;
  assign tay_sum = cnt_q[0] ? sum_q - {1'b0, qcor} : sum_q + {1'b0, qcor};
  assign log_sum = sum_q + {1'b0, qcor};
  assign v_new   = 31'(tay_sum >> k_q);

  // divider step
  logic [32:0] rem_sh, rem_nx;
  logic        div_ge;
  logic [63:0] dq_nx;
  assign rem_sh = {rem_q[31:0], dq_q[63]};
  assign div_ge = rem_sh >= {1'b0, dv_q};
  assign rem_nx = div_ge ? rem_sh - {1'b0, dv_q} : rem_sh;
  assign dq_nx  = {dq_q[62:0], div_ge};

  // weighted loss
  logic [48:0] acc2;
  logic [46:0] lw_new;
  assign acc2   = prod_q[48:0] + {17'b0, acc_q[63:32]};
  assign lw_new = (acc2[48:31] != '0) ? LOSS_MAX : {acc2[30:0], acc_q[31:16]};

  // weighted residual
  logic [48:0] pw;
  logic [47:0] pr_new;
  assign pw = prod_q[64:16];
  always_comb begin
    if (neg_q) begin
      pr_new = (pw > 49'h0800000000000) ? 48'h800000000000 : 48'(-pw);
    end else begin
      pr_new = (pw > {2'b00, LOSS_MAX}) ? {1'b0, LOSS_MAX} : pw[47:0];
    end
  end

  // accumulator update
  logic [64:0]      sum_add;
  logic [63:0]      sum_nx;
  logic [CNT_W-1:0] count_nx;
  assign sum_add  = {1'b0, loss_sum_q} + {18'b0, lw_q};
  assign sum_nx   = sum_add[64] ? '1 : sum_add[63:0];
  assign count_nx = (count_q < CNT_W'(MAX_ITEMS)) ? count_q + CNT_W'(1) : count_q;

  // binomial loss pieces
  logic [31:0] t_pos;
  assign t_pos = (!t_q[32] && t_q != 33'sd0) ? t_q[31:0] : 32'd0;

  // ---------------- shared multiplier operands ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_LQ: begin
        if (mode_q == MODE_QUAD || (mode_q == MODE_HUBER && hub_small)) begin
          mul_a = {1'b0, a_q};
          mul_b = a_q;
        end else if (mode_q == MODE_HUBER) begin
          mul_a = hub_span;
          mul_b = {2'b00, hdelta_q};
        end else if (mode_q == MODE_QUANT) begin
          mul_a = {1'b0, a_q};
          mul_b = 33'(qc);
        end
      end
      S_TMUL: begin
        mul_a = 34'(term_q);
        mul_b = log_ph_q ? 33'(s2_q) : 33'(f_q);
      end
      S_TREC: begin
        mul_a = 34'(x_new);
        mul_b = recip(dconst);
      end
      S_LSQ: begin
        mul_a = 34'(term_q);
        mul_b = 33'(term_q);
      end
      S_LWLO: begin
        mul_a = 34'(lq_q[31:0]);
        mul_b = 33'(w_q);
      end
      S_LWHI: begin
        mul_a = 34'(lq_q[47:32]);
        mul_b = 33'(w_q);
      end
      S_LWF: begin
        mul_a = {1'b0, mag_q};
        mul_b = 33'(w_q);
      end
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  assign out_load = (state_q == S_OUT) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (item_i.valid) state_d = (mode_q == MODE_BINOM) ? S_EXPC : S_LQ;
      S_LQ:   state_d = S_LQF;
      S_LQF:  state_d = S_LWLO;
      S_EXPC: state_d = exp_big ? S_LOGS : S_DIV;
      S_LOGS: state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == 7'd1) begin
          case (dop_q)
            DOP_EXP: state_d = S_TMUL;
            DOP_LOG: state_d = S_LSQ;
            DOP_SIG: state_d = S_BFIN;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_TMUL: state_d = S_TREC;
      S_TREC: state_d = S_TCOR;
      S_TCOR: begin
        if (log_ph_q) state_d = (cnt_q == 4'd6) ? S_SIGS : S_TMUL;
        else          state_d = (cnt_q == 4'd10) ? S_LOGS : S_TMUL;
      end
      S_LSQ:  state_d = S_LSQF;
      S_LSQF: state_d = S_TMUL;
      S_SIGS: state_d = S_DIV;
      S_BFIN: state_d = S_LWLO;
      S_LWLO: state_d = S_LWHI;
      S_LWHI: state_d = S_LWF;
      S_LWF:  state_d = S_PWF;
      S_PWF:  state_d = last_q ? S_DIV : S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign item_i.ready    = (state_q == S_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_data_q;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      loss_sum_q  <= '0;
      count_q     <= '0;
      mode_q      <= MODE_QUAD;
      qlvl_q      <= 17'd32768;
      hdelta_q    <= 31'd65536;
    end else begin
      state_q <= state_d;

      if (out_load)             out_valid_q <= 1'b1;
      else if (result_o.ready)  out_valid_q <= 1'b0;

      if (state_q == S_PWF) begin
        loss_sum_q <= sum_nx;
        count_q    <= count_nx;
      end else if (out_load && last_q) begin
        loss_sum_q <= '0;
        count_q    <= '0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LOSS_MODE:      mode_q   <= cfg_data_i[2:0];
          CFG_QUANTILE_LEVEL: qlvl_q   <= cfg_data_i[16:0];
          CFG_HUBER_DELTA:    hdelta_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    prod_q <= 67'(mul_a) * 67'(mul_b);

    case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          a_q    <= in_a;
          rneg_q <= in_r[32];
          rnz_q  <= (in_r != 33'sd0);
          t_q    <= in_t;
          at_q   <= in_t[32] ? 32'(-in_t) : in_t[31:0];
          sneg_q <= in_yneg;
          snz_q  <= in_yneg || in_ypos;
          w_q    <= item_i.data.obs_weight;
          last_q <= item_i.data.last_item;
        end
      end

      // plain losses
      S_LQF: begin
        neg_q <= rneg_q;
        case (mode_q)
          MODE_QUAD: begin
            lq_q  <= prod_q[64:17];
            mag_q <= a_q;
          end
          MODE_ABS: begin
            lq_q  <= 48'(a_q);
            mag_q <= rnz_q ? 33'(1 << FRAC_BITS) : 33'd0;
          end
          MODE_QUANT: begin
            lq_q  <= prod_q[63:16];
            mag_q <= rnz_q ? 33'(qc) : 33'd0;
          end
          MODE_HUBER: begin
            lq_q  <= prod_q[64:17];
            mag_q <= hub_small ? a_q : (rnz_q ? {2'b00, hdelta_q} : 33'd0);
          end
          default: begin
            lq_q  <= '0;
            mag_q <= '0;
          end
        endcase
      end

      // exp: range reduction by ln2
      S_EXPC: begin
        if (exp_big) begin
          v_q <= '0;
        end else begin
          rem_q  <= u30[38:6];
          dq_q   <= {u30[5:0], 58'b0};
          dv_q   <= 32'(LN2_I);
          dcnt_q <= 7'd6;
          dop_q  <= DOP_EXP;
        end
      end

      // ln(1+v): s = v / (2 + v)
      S_LOGS: begin
        rem_q  <= {3'b000, v_q[30:1]};
        dq_q   <= {v_q[0], 63'b0};
        dv_q   <= 32'h80000000 + 32'(v_q);
        dcnt_q <= 7'd31;
        dop_q  <= DOP_LOG;
      end

      S_DIV: begin
        rem_q  <= rem_nx;
        dq_q   <= dq_nx;
        dcnt_q <= dcnt_q - 7'd1;
        if (dcnt_q == 7'd1) begin
          if (dop_q == DOP_EXP) begin
            f_q      <= rem_nx[29:0];
            k_q      <= dq_nx[5:0];
            term_q   <= 31'(1 << IBITS);
            sum_q    <= 32'(1 << IBITS);
            cnt_q    <= 4'd1;
            log_ph_q <= 1'b0;
          end else if (dop_q == DOP_LOG) begin
            term_q <= dq_nx[30:0];
            sum_q  <= {1'b0, dq_nx[30:0]};
          end
        end
      end

      S_TREC: begin
        x_q <= x_new;
        if (log_ph_q) term_q <= x_new;
      end

      S_TCOR: begin
        cnt_q <= cnt_q + 4'd1;
        if (log_ph_q) begin
          sum_q <= log_sum;
        end else begin
          term_q <= qcor;
          sum_q  <= tay_sum;
          if (cnt_q == 4'd10) v_q <= v_new;
        end
      end

      S_LSQF: begin
        s2_q     <= prod_q[60:30];
        cnt_q    <= 4'd1;
        log_ph_q <= 1'b1;
      end

      // sigmoid: one division by 1 + v
      S_SIGS: begin
        if (!t_q[32]) begin
          rem_q <= 33'h020000000;
          dq_q  <= '0;
        end else begin
          rem_q <= {3'b000, v_q[30:1]};
          dq_q  <= {v_q[0], 63'b0};
        end
        dv_q   <= 32'h40000000 + 32'(v_q);
        dcnt_q <= 7'd31;
        dop_q  <= DOP_SIG;
      end

      S_BFIN: begin
        lq_q  <= 48'(t_pos) + 48'(sum_q >> 13);
        mag_q <= snz_q ? 33'(dq_q[30:14]) : 33'd0;
        neg_q <= sneg_q;
      end

      S_LWHI: acc_q <= prod_q[63:0];
      S_LWF:  lw_q  <= lw_new;

      // residual, then the mean division on a last item
      S_PWF: begin
        pr_q <= pr_new;
        if (last_q) begin
          rem_q  <= '0;
          dq_q   <= sum_nx;
          dv_q   <= 32'(count_nx);
          dcnt_q <= 7'd64;
          dop_q  <= DOP_MEAN;
        end
      end

      S_OUT: begin
        if (out_load) begin
          out_data_q.loss_out        <= lw_q;
          out_data_q.pseudo_residual <= pr_q;
          out_data_q.risk_valid      <= last_q;
          if (!last_q)                 out_data_q.mean_risk <= '0;
          else if (dq_q[63:47] != '0)  out_data_q.mean_risk <= LOSS_MAX;
          else                         out_data_q.mean_risk <= dq_q[46:0];
        end
      end

      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < {1'b0, dv_q}))
    else $error("divider remainder not below divisor");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("item count above limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> (count_q == '0 && loss_sum_q == '0))
    else $error("accumulators not cleared after last item");

  a_series_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TCOR) |-> (cnt_q >= 4'd1 && cnt_q <= 4'd10))
    else $error("series index out of range");

  a_mean_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.risk_valid) |-> (out_data_q.mean_risk == '0))
    else $error("mean risk shown on an item that is not last");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import blgu_pkg::*;

  localparam int unsigned MAX_CNT = 1048576;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned LMAX = (64'd1 << 47) - 1;
  localparam longint unsigned NMAX = 64'd1 << 47;

  // Scoreboard: loss model state plus the queue of expected results
  class loss_scoreboard;
    bit [2:0]        mode;
    bit [16:0]       qlevel;
    bit [30:0]       hdelta;
    longint unsigned risk_sum;
    int unsigned     risk_cnt;
    blgu_out_t       pending[$];
    int              errors;

    function new();
      mode = MODE_QUAD; qlevel = 17'd32768; hdelta = 31'd65536;
      risk_sum = 0; risk_cnt = 0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_LOSS_MODE:      mode = val[2:0];
        CFG_QUANTILE_LEVEL: qlevel = val[16:0];
        CFG_HUBER_DELTA:    hdelta = val[30:0];
        default: ;
      endcase
    endfunction

    // (a*b) >> 16 over a full product, saturated to 64 bits
    function longint unsigned scale_q16(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      p = p >> 16;
      if (p[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
      return p[63:0];
    endfunction

    function longint unsigned exp_neg_q30(longint unsigned u);
      longint unsigned u30, k, f, term;
      longint sum;
      u30 = u << 14;
      k = u30 / LN2_Q30;
      if (k > 62) return 0;
      f = u30 - k * LN2_Q30;
      term = ONE_Q30; sum = longint'(ONE_Q30);
      for (int i = 1; i <= 10; i++) begin
        term = ((term * f) >> 30) / i;
        if (i % 2) sum -= longint'(term); else sum += longint'(term);
      end
      return longint'(unsigned'(sum)) >> k;
    endfunction

    function longint unsigned log1p_q30(longint unsigned v);
      longint unsigned s, s2, p, acc;
      s = (v << 30) / (2 * ONE_Q30 + v);
      s2 = (s * s) >> 30;
      p = s; acc = s;
      for (int k = 1; k <= 6; k++) begin
        p = (p * s2) >> 30;
        acc += p / (2 * k + 1);
      end
      return 2 * acc;
    endfunction

    function void note_item(blgu_in_t it);
      longint tv, pv, r, s, t;
      longint unsigned a, w, lq, mag, lw, pw, q, c, d, at, v, sig, m;
      bit neg;
      blgu_out_t e;
      tv = it.true_val; pv = it.pred_val; w = it.obs_weight;
      r = tv - pv;
      a = (r < 0) ? -r : r;
      lq = 0; mag = 0; neg = 0;
      case (mode)
        MODE_QUAD: begin
          lq = (a * a) >> 17; mag = a; neg = r < 0;
        end
        MODE_ABS: begin
          lq = a; mag = (r != 0) ? 64'd65536 : 0; neg = r < 0;
        end
        MODE_QUANT: begin
          q = (qlevel > Q_ONE) ? 64'd65536 : qlevel;
          c = (r < 0) ? 2 * (65536 - q) : 2 * q;
          lq = (a * c) >> 16;
          mag = (r != 0) ? c : 0; neg = r < 0;
        end
        MODE_HUBER: begin
          d = hdelta;
          if (a < d) begin
            lq = (a * a) >> 17; mag = a;
          end else begin
            lq = scale_q16(d, 2 * a - d) >> 1;
            mag = (r != 0) ? d : 0;
          end
          neg = r < 0;
        end
        MODE_BINOM: begin
          s = (tv > 0) ? 1 : ((tv < 0) ? -1 : 0);
          t = -(s * pv);
          at = (t < 0) ? -t : t;
          v = exp_neg_q30(at);
          sig = (t >= 0) ? ((ONE_Q30 << 30) / (ONE_Q30 + v)) : ((v << 30) / (ONE_Q30 + v));
          lq = ((t > 0) ? t : 0) + (log1p_q30(v) >> 14);
          mag = (s != 0) ? (sig >> 14) : 0;
          neg = s < 0;
        end
        default: ;
      endcase
      lw = scale_q16(lq, w);
      if (lw > LMAX) lw = LMAX;
      pw = scale_q16(mag, w);
      if (neg) begin
        if (pw > NMAX) pw = NMAX;
        pw = -pw;
      end else if (pw > LMAX) begin
        pw = LMAX;
      end
      risk_sum = (64'hFFFF_FFFF_FFFF_FFFF - risk_sum < lw) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : risk_sum + lw;
      if (risk_cnt < MAX_CNT) risk_cnt++;
      e.loss_out = lw[46:0];
      e.pseudo_residual = pw[47:0];
      e.mean_risk = '0;
      e.risk_valid = 1'b0;
      if (it.last_item) begin
        m = (risk_cnt != 0) ? risk_sum / risk_cnt : 0;
        e.mean_risk = (m > LMAX) ? LMAX[46:0] : m[46:0];
        e.risk_valid = 1'b1;
        risk_sum = 0; risk_cnt = 0;
      end
      pending.push_back(e);
    endfunction

    function void check_result(blgu_out_t got);
      blgu_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.loss_out !== e.loss_out) begin
        $display("%0t: loss_out exp %h got %h", $time, e.loss_out, got.loss_out);
        errors++;
      end
      if (got.pseudo_residual !== e.pseudo_residual) begin
        $display("%0t: pseudo_residual exp %h got %h", $time, e.pseudo_residual,
                 got.pseudo_residual);
        errors++;
      end
      if (got.mean_risk !== e.mean_risk) begin
        $display("%0t: mean_risk exp %h got %h", $time, e.mean_risk, got.mean_risk);
        errors++;
      end
      if (got.risk_valid !== e.risk_valid) begin
        $display("%0t: risk_valid exp %b got %b", $time, e.risk_valid, got.risk_valid);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  blgu_in_if  obs_ch ();
  blgu_out_if res_ch ();

  boosting_loss_gradient_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .item_i(obs_ch.sink), .result_o(res_ch.source)
  );

  loss_scoreboard sb = new();
  bit stall_enable = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    obs_ch.valid = 1'b0;
    obs_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // Receiver: stalls at random while stall_enable is set
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    if (!stall_enable) res_ch.ready <= 1'b1;
    else res_ch.ready <= ($urandom_range(0, 99) < 60);
  end

  // Input monitor
  always @(posedge clk_i) begin
    if (rst_ni && obs_ch.valid && obs_ch.ready) sb.note_item(obs_ch.data);
  end

  task automatic send_obs(logic signed [31:0] y, logic signed [31:0] p,
                          logic [31:0] w, logic last);
    blgu_in_t it;
    it.true_val = y; it.pred_val = p; it.obs_weight = w; it.last_item = last;
    obs_ch.valid <= 1'b1;
    obs_ch.data <= it;
    do @(posedge clk_i); while (!obs_ch.ready);
  endtask

  task automatic pause_obs();
    int n;
    obs_ch.valid <= 1'b0;
    n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
    repeat (n) @(posedge clk_i);
  endtask

  // Settle: all results in, then room for any item still in flight
  task automatic drain();
    obs_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 8) << 16;
      1: return -($urandom_range(0, 8) << 16);
      2: return $urandom_range(0, 262143) - 131072;
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7FFF_FFFF};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return 32'd65536;
      1: return $urandom_range(0, 131072);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_block(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (n > 0) begin
          send_obs(rand_val(), rand_val(), rand_weight(), $urandom_range(0, 5) == 0);
          n--;
        end
      end
      pause_obs();
    end
  endtask

  initial begin
    logic [2:0] modes[8];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes under reset settings, then each mode, an unused mode code and an unused register index
    send_obs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_obs(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_obs(32'sd0, 32'sd0, 32'd0, 1'b1);
    send_obs(32'sd65536, 32'sd0, 32'd65536, 1'b1);
    drain();
    write_reg(CFG_LOSS_MODE, CFG_DW'(MODE_ABS));
    send_obs(32'sd5, 32'sd5, 32'd65536, 1'b0);
    send_obs(-32'sd65536, 32'sd65536, 32'd65536, 1'b1);
    drain();
    write_reg(CFG_LOSS_MODE, CFG_DW'(MODE_QUANT));
    write_reg(CFG_QUANTILE_LEVEL, 31'h1FFFF);
    send_obs(32'sd65536, 32'sd0, 32'd65536, 1'b0);
    send_obs(-32'sd65536, 32'sd0, 32'd65536, 1'b1);
    drain();
    write_reg(CFG_QUANTILE_LEVEL, 31'd0);
    send_obs(32'sd65536, 32'sd0, 32'd65536, 1'b0);
    send_obs(-32'sd65536, 32'sd0, 32'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(CFG_LOSS_MODE, CFG_DW'(MODE_HUBER));
    write_reg(CFG_HUBER_DELTA, 31'd0);
    send_obs(32'sd7, 32'sd7, 32'd65536, 1'b0);
    send_obs(32'sd65536, 32'sd0, 32'd65536, 1'b1);
    drain();
    write_reg(CFG_HUBER_DELTA, 31'h7FFF_FFFF);
    send_obs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(CFG_LOSS_MODE, CFG_DW'(MODE_BINOM));
    send_obs(32'sd0, 32'sd12345, 32'd65536, 1'b0);
    send_obs(32'sd65536, 32'sh7FFF_FFFF, 32'd65536, 1'b0);
    send_obs(-32'sd65536, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_obs(32'sd1, -32'sd131072, 32'd65536, 1'b1);
    drain();
    write_reg(CFG_LOSS_MODE, 31'd7);
    send_obs(32'sd65536, 32'sd0, 32'd65536, 1'b0);
    send_obs(32'sd0, 32'sd0, 32'd65536, 1'b1);
    drain();
    write_reg(2'd3, 31'h5A5A);

    // Random phases over every mode and a range of register values
    modes = '{MODE_QUAD, MODE_ABS, MODE_QUANT, MODE_HUBER, MODE_BINOM, 3'd5,
              MODE_HUBER, MODE_QUANT};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_LOSS_MODE, CFG_DW'(modes[ph]));
      write_reg(CFG_QUANTILE_LEVEL, CFG_DW'($urandom_range(0, 131071)));
      write_reg(CFG_HUBER_DELTA,
                ph[0] ? CFG_DW'($urandom_range(0, 327680)) : CFG_DW'($urandom()));
      stall_enable = (ph != 3);
      random_block(ph == 4 ? 40 : 50);
      drain();
    end

    // Allow for the last results, then report
    drain();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
